### rtl/swm_pkg.sv
// Sliding window median: shared constants and defaults.
// No dependencies; imported by the top level.
`timescale 1ns / 1ps

package swm_pkg;

  localparam int VALUE_BITS_DEF = 16;    // sample value bits used by the tree
  localparam int WINDOW_MAX_DEF = 4096;  // depth of the sample ring
  localparam int SAMPLE_W       = 16;    // sample / median port width
  localparam int CFG_W          = 13;    // window length register width

endpackage

### rtl/sliding_window_median_top.sv
// Sliding window median filter, top level; uses swm_pkg and swm_ram.
// Count-in, rank descent and count-out each walk the tree one level per cycle
// on the single tree RAM, then the output register is loaded.
// One word at a time: a new sample is taken only once the last one's median is handed on
// (or, while the window fills, once it is counted in); a result may wait on out_ready.
// Reset (rst_n, sync) and every cfg write clear the tree.
`timescale 1ns / 1ps

module sliding_window_median_top #(
  parameter int VALUE_BITS = swm_pkg::VALUE_BITS_DEF,
  parameter int WINDOW_MAX = swm_pkg::WINDOW_MAX_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // input channel
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [swm_pkg::SAMPLE_W-1:0] in_sample,
  // result channel
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [swm_pkg::SAMPLE_W-1:0] out_median,
  // configuration
  input  logic                         cfg_we,
  input  logic [swm_pkg::CFG_W-1:0]    cfg_window_length
);

  import swm_pkg::*;

  // Tree: node 1 is the root (never stored), leaves at 2^VALUE_BITS + value, node 0 unused.
  localparam int NODE_W = VALUE_BITS + 1;
  localparam int CNT_W  = $clog2(WINDOW_MAX + 1);       // counts never exceed the window
  localparam int PTR_W  = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;

  typedef enum logic [5:0] {
    ST_CLEAR = 6'b000001,  // zeroing sweep over the tree
    ST_IDLE  = 6'b000010,  // ready for a word
    ST_INS   = 6'b000100,  // count new sample in, leaf to root
    ST_SEL   = 6'b001000,  // rank descent, root to leaf
    ST_REM   = 6'b010000,  // count oldest sample out, leaf to root
    ST_PUSH  = 6'b100000   // hand the median to the output register
  } state_t;

  state_t                state_r, state_nxt;
  logic [NODE_W-1:0]     clr_r, clr_nxt;
  logic [NODE_W-1:0]     node_r, node_nxt;
  logic                  pend_r, pend_nxt;          // a tree write is due this cycle
  logic [NODE_W-1:0]     pend_addr_r, pend_addr_nxt;
  logic                  primed_r, primed_nxt;      // descent has its first read out
  logic [CNT_W-1:0]      rank_r, rank_nxt;
  logic [CNT_W-1:0]      k_r, k_nxt;
  logic [CNT_W-1:0]      fill_r, fill_nxt;
  logic [PTR_W-1:0]      wp_r, wp_nxt;
  logic [VALUE_BITS-1:0] med_r, med_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [SAMPLE_W-1:0]   out_median_r, out_median_nxt;

  // tree RAM ports
  logic                  t_we, t_re;
  logic [NODE_W-1:0]     t_waddr, t_raddr;
  logic [CNT_W-1:0]      t_wdata, t_rdata;
  logic [CNT_W-1:0]      rmw_sum;

  // sample ring ports
  logic                  s_re;
  logic [PTR_W-1:0]      s_raddr;
  logic [VALUE_BITS-1:0] s_rdata;

  logic                  in_acc;
  logic                  node_live;
  logic                  go_right;
  logic [NODE_W-1:0]     sel_next;
  logic [CNT_W-1:0]      filled;
  logic [CNT_W-1:0]      km1;
  logic [CNT_W:0]        kp1;
  logic [CNT_W:0]        wp_ext;
  logic [CNT_W:0]        km1_ext;
  logic [CNT_W:0]        oldest_w;
  logic [PTR_W-1:0]      wp_inc;
  logic [31:0]           len32;
  logic [31:0]           k32;
  logic                  out_free;

  assign in_ready   = (state_r == ST_IDLE);
  assign in_acc     = in_valid && in_ready;
  assign out_valid  = out_valid_r;
  assign out_median = out_median_r;
  assign out_free   = !out_valid_r || out_ready;

  // effective window length: zero acts as one, saturate at ring depth
  assign len32 = 32'(cfg_window_length);
  always_comb begin
    if (len32 == 32'd0) begin
      k32 = 32'd1;
    end else if (len32 > 32'(WINDOW_MAX)) begin
      k32 = 32'(WINDOW_MAX);
    end else begin
      k32 = len32;
    end
  end

  // shared count unit: +1 on count-in, -1 on count-out
  assign rmw_sum = (state_r == ST_REM) ? t_rdata - CNT_W'(1) : t_rdata + CNT_W'(1);

  // path walk stops below the root
  assign node_live = |node_r[NODE_W-1:1];

  // descent step: go right when the left subtree holds fewer than rank samples
  assign go_right = (t_rdata < rank_r);
  assign sel_next = {node_r[NODE_W-2:0], go_right};

  assign filled = fill_r + CNT_W'(1);
  assign km1    = k_r - CNT_W'(1);
  assign kp1    = {1'b0, k_r} + (CNT_W+1)'(1);

  // oldest entry sits k-1 words behind the one just written, modulo the ring depth
  assign wp_ext   = (CNT_W+1)'(wp_r);
  assign km1_ext  = {1'b0, km1};
  assign oldest_w = (wp_ext >= km1_ext) ? wp_ext - km1_ext
                                        : wp_ext + (CNT_W+1)'(WINDOW_MAX) - km1_ext;
  assign s_raddr  = oldest_w[PTR_W-1:0];

  assign wp_inc = (wp_r == PTR_W'(WINDOW_MAX - 1)) ? '0 : wp_r + PTR_W'(1);

  always_comb begin
    state_nxt      = state_r;
    clr_nxt        = clr_r;
    node_nxt       = node_r;
    pend_nxt       = pend_r;
    pend_addr_nxt  = pend_addr_r;
    primed_nxt     = primed_r;
    rank_nxt       = rank_r;
    k_nxt          = k_r;
    fill_nxt       = fill_r;
    wp_nxt         = wp_r;
    med_nxt        = med_r;
    out_valid_nxt  = out_valid_r;
    out_median_nxt = out_median_r;
    t_we           = 1'b0;
    t_waddr        = pend_addr_r;
    t_wdata        = rmw_sum;
    t_re           = 1'b0;
    t_raddr        = node_r;
    s_re           = 1'b0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_CLEAR: begin
        t_we    = 1'b1;
        t_waddr = clr_r;
        t_wdata = '0;
        clr_nxt = clr_r + NODE_W'(1);
        if (&clr_r) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          node_nxt  = {1'b1, in_sample[VALUE_BITS-1:0]};
          pend_nxt  = 1'b0;
          state_nxt = ST_INS;
        end
      end
      ST_INS, ST_REM: begin
        // read this level, write back the level read last cycle
        t_re          = node_live;
        t_we          = pend_r;
        pend_nxt      = node_live;
        pend_addr_nxt = node_r;
        node_nxt      = node_r >> 1;
        if (!node_live) begin
          if (state_r == ST_INS) begin
            if (filled < k_r) begin
              // window still filling: no median
              fill_nxt  = filled;
              wp_nxt    = wp_inc;
              state_nxt = ST_IDLE;
            end else begin
              node_nxt   = NODE_W'(1);
              primed_nxt = 1'b0;
              rank_nxt   = kp1[CNT_W:1];
              state_nxt  = ST_SEL;
            end
          end else begin
            fill_nxt  = km1;
            wp_nxt    = wp_inc;
            state_nxt = ST_PUSH;
          end
        end
      end
      ST_SEL: begin
        if (!primed_r) begin
          t_re       = 1'b1;
          t_raddr    = {node_r[NODE_W-2:0], 1'b0};
          s_re       = 1'b1;            // fetch the oldest sample for count-out
          primed_nxt = 1'b1;
        end else begin
          rank_nxt = go_right ? rank_r - t_rdata : rank_r;
          node_nxt = sel_next;
          if (sel_next[NODE_W-1]) begin
            med_nxt   = sel_next[VALUE_BITS-1:0];
            node_nxt  = {1'b1, s_rdata};
            pend_nxt  = 1'b0;
            state_nxt = ST_REM;
          end else begin
            t_re    = 1'b1;
            t_raddr = {sel_next[NODE_W-2:0], 1'b0};
          end
        end
      end
      ST_PUSH: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_median_nxt = SAMPLE_W'(med_r);
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // register write restarts the window
    if (cfg_we) begin
      k_nxt     = CNT_W'(k32);
      fill_nxt  = '0;
      wp_nxt    = '0;
      clr_nxt   = '0;
      state_nxt = ST_CLEAR;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      clr_r        <= '0;
      node_r       <= '0;
      pend_r       <= 1'b0;
      pend_addr_r  <= '0;
      primed_r     <= 1'b0;
      rank_r       <= '0;
      k_r          <= CNT_W'(1);
      fill_r       <= '0;
      wp_r         <= '0;
      med_r        <= '0;
      out_valid_r  <= 1'b0;
      out_median_r <= '0;
    end else begin
      state_r      <= state_nxt;
      clr_r        <= clr_nxt;
      node_r       <= node_nxt;
      pend_r       <= pend_nxt;
      pend_addr_r  <= pend_addr_nxt;
      primed_r     <= primed_nxt;
      rank_r       <= rank_nxt;
      k_r          <= k_nxt;
      fill_r       <= fill_nxt;
      wp_r         <= wp_nxt;
      med_r        <= med_nxt;
      out_valid_r  <= out_valid_nxt;
      out_median_r <= out_median_nxt;
    end
  end

  swm_ram #(
    .WIDTH (CNT_W),
    .DEPTH (1 << NODE_W)
  ) u_tree_ram (
    .clk   (clk),
    .we    (t_we),
    .waddr (t_waddr),
    .wdata (t_wdata),
    .re    (t_re),
    .raddr (t_raddr),
    .rdata (t_rdata)
  );

  swm_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (WINDOW_MAX)
  ) u_ring_ram (
    .clk   (clk),
    .we    (in_acc),
    .waddr (wp_r),
    .wdata (in_sample[VALUE_BITS-1:0]),
    .re    (s_re),
    .raddr (s_raddr),
    .rdata (s_rdata)
  );

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |=> out_valid_r && $stable(out_median_r));

  a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r));

  a_fill_below_len: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r < k_r);

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_ready);

  a_rank_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SEL |-> rank_r != '0);

endmodule

### rtl/swm_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`timescale 1ns / 1ps

module swm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    // read data holds while re is low
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
